// ===== hdl/stp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, codes and constants of the step/dir pulse generator.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int POSITION_BITS_DEF = 32;

  // word field widths
  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 2;

  // configuration registers
  localparam int PULSE_W  = 10;
  localparam int SETUP_W  = 8;
  localparam int TRAVEL_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int STEPS_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_TRAVEL = 2'd2;

  localparam logic [PULSE_W-1:0]  PULSE_HIGH_RST  = 10'd5;
  localparam logic [SETUP_W-1:0]  DIR_SETUP_RST   = 8'd2;
  localparam logic [TRAVEL_W-1:0] HOME_TRAVEL_RST = 20'd2000;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_REL  = 2'd1,
    REQ_ABS  = 2'd2,
    REQ_HOME = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulse_high_us;
    logic [SETUP_W-1:0]  dir_setup_us;
    logic [TRAVEL_W-1:0] home_travel_steps;
  } cfg_t;

  typedef struct packed {
    logic                       step_pin;
    logic                       dir_pin;
    logic signed [VALUE_W-1:0]  position_steps;
    logic                       busy_res;
    status_t                    status;
  } res_t;

endpackage

// ===== hdl/stp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_req_if
// Request channel: ticks and motion commands.
// ----------------------------------------------------------------------------
interface stp_req_if;
  logic                                valid;
  logic                                ready;
  logic [stp_pkg::REQ_W-1:0]           req_type;
  logic signed [stp_pkg::VALUE_W-1:0]  step_value;
  logic [stp_pkg::PERIOD_W-1:0]        period_us;

  modport source (output valid, req_type, step_value, period_us, input ready);
  modport sink   (input valid, req_type, step_value, period_us, output ready);
endinterface

// ===== hdl/stp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_res_if
// Result channel: pin levels, position and command status.
// ----------------------------------------------------------------------------
interface stp_res_if;
  logic                                valid;
  logic                                ready;
  logic                                step_pin;
  logic                                dir_pin;
  logic signed [stp_pkg::VALUE_W-1:0]  position_steps;
  logic                                busy_res;
  logic [stp_pkg::STATUS_W-1:0]        status;

  modport source (output valid, step_pin, dir_pin, position_steps, busy_res, status,
                  input ready);
  modport sink   (input valid, step_pin, dir_pin, position_steps, busy_res, status,
                  output ready);
endinterface

// ===== hdl/stp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface stp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stp_pkg::CFG_IDX_W-1:0]     index;
  logic [stp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/stp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_core
// Motion state and per-word update: step timing, position and command checks.
// ----------------------------------------------------------------------------
module stp_core #(
  parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [stp_pkg::REQ_W-1:0]           req_type,
  input  logic signed [stp_pkg::VALUE_W-1:0]  step_value,
  input  logic [stp_pkg::PERIOD_W-1:0]        period_us,
  input  stp_pkg::cfg_t                       cfg,
  output stp_pkg::res_t                       res
);

  localparam int DW = ((POSITION_BITS > stp_pkg::VALUE_W) ? POSITION_BITS
                                                          : stp_pkg::VALUE_W) + 1;

  stp_pkg::phase_t                     phase, phase_next;
  logic signed [POSITION_BITS-1:0]     position, position_next;
  logic [stp_pkg::STEPS_W-1:0]         steps_left, steps_left_next;
  logic [stp_pkg::PERIOD_W-1:0]        phase_ticks, phase_ticks_next;
  logic [stp_pkg::PERIOD_W-1:0]        low_time, low_time_next;
  logic                                direction, direction_next;
  logic                                homing, homing_next;

  logic [stp_pkg::PULSE_W-1:0]         pulse_eff;
  logic [stp_pkg::PERIOD_W-1:0]        ticks_dec;
  logic [stp_pkg::STEPS_W-1:0]         steps_dec;
  logic [stp_pkg::STEPS_W-1:0]         rel_mag;
  logic signed [DW-1:0]                t_ext, p_ext, diff_up, diff_dn;
  logic [DW-1:0]                       abs_mag;
  logic [stp_pkg::STEPS_W-1:0]         count;
  logic                                fwd;
  logic                                slow_ok;
  stp_pkg::status_t                    status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= stp_pkg::PH_IDLE;
      position    <= '0;
      steps_left  <= '0;
      phase_ticks <= '0;
      low_time    <= '0;
      direction   <= 1'b0;
      homing      <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      position    <= position_next;
      steps_left  <= steps_left_next;
      phase_ticks <= phase_ticks_next;
      low_time    <= low_time_next;
      direction   <= direction_next;
      homing      <= homing_next;
    end
  end

  // step count and direction of a command
  always_comb begin
    pulse_eff = (cfg.pulse_high_us == '0) ? stp_pkg::PULSE_W'(1) : cfg.pulse_high_us;
    slow_ok   = period_us >= stp_pkg::PERIOD_W'({pulse_eff, 1'b0});
    rel_mag   = step_value[stp_pkg::VALUE_W-1] ? stp_pkg::STEPS_W'(-step_value)
                                               : stp_pkg::STEPS_W'(step_value);
    t_ext     = DW'(step_value);
    p_ext     = DW'(position);
    diff_up   = t_ext - p_ext;
    diff_dn   = p_ext - t_ext;
    abs_mag   = (t_ext > p_ext) ? diff_up : diff_dn;
    count     = '0;
    fwd       = 1'b0;
    case (stp_pkg::req_t'(req_type))
      stp_pkg::REQ_REL: begin
        count = rel_mag;
        fwd   = ~step_value[stp_pkg::VALUE_W-1];
      end
      stp_pkg::REQ_ABS: begin
        // saturate far targets
        count = (|abs_mag[DW-1:stp_pkg::STEPS_W]) ? '1 : abs_mag[stp_pkg::STEPS_W-1:0];
        fwd   = t_ext > p_ext;
      end
      stp_pkg::REQ_HOME: begin
        count = stp_pkg::STEPS_W'(cfg.home_travel_steps);
      end
      default: begin
        count = '0;
      end
    endcase
  end

  always_comb begin
    phase_next       = phase;
    position_next    = position;
    steps_left_next  = steps_left;
    phase_ticks_next = phase_ticks;
    low_time_next    = low_time;
    direction_next   = direction;
    homing_next      = homing;
    status           = stp_pkg::ST_NONE;
    ticks_dec        = (phase_ticks != '0) ? phase_ticks - 1'b1 : phase_ticks;
    steps_dec        = (steps_left != '0) ? steps_left - 1'b1 : steps_left;

    if (stp_pkg::req_t'(req_type) == stp_pkg::REQ_TICK) begin
      if (phase != stp_pkg::PH_IDLE) begin
        phase_ticks_next = ticks_dec;
        if (ticks_dec == '0) begin
          unique case (phase)
            stp_pkg::PH_SETUP: begin
              phase_next       = stp_pkg::PH_HIGH;
              phase_ticks_next = stp_pkg::PERIOD_W'(pulse_eff);
            end
            stp_pkg::PH_HIGH: begin
              phase_next       = stp_pkg::PH_LOW;
              phase_ticks_next = (low_time == '0) ? stp_pkg::PERIOD_W'(1) : low_time;
            end
            stp_pkg::PH_LOW: begin
              position_next   = direction ? position + POSITION_BITS'(1)
                                          : position - POSITION_BITS'(1);
              steps_left_next = steps_dec;
              if (steps_dec == '0) begin
                phase_next  = stp_pkg::PH_IDLE;
                homing_next = 1'b0;
                if (homing) begin
                  position_next = '0;
                end
              end else begin
                phase_next       = stp_pkg::PH_HIGH;
                phase_ticks_next = stp_pkg::PERIOD_W'(pulse_eff);
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end else if (phase != stp_pkg::PH_IDLE) begin
      status = stp_pkg::ST_IGNORED;
    end else if (count == '0 || !slow_ok) begin
      status = stp_pkg::ST_REJECTED;
      if (stp_pkg::req_t'(req_type) == stp_pkg::REQ_HOME) begin
        position_next = '0;
      end
    end else begin
      status          = stp_pkg::ST_ACCEPTED;
      direction_next  = fwd;
      steps_left_next = count;
      low_time_next   = period_us - stp_pkg::PERIOD_W'(pulse_eff);
      homing_next     = stp_pkg::req_t'(req_type) == stp_pkg::REQ_HOME;
      if (cfg.dir_setup_us == '0) begin
        phase_next       = stp_pkg::PH_HIGH;
        phase_ticks_next = stp_pkg::PERIOD_W'(pulse_eff);
      end else begin
        phase_next       = stp_pkg::PH_SETUP;
        phase_ticks_next = stp_pkg::PERIOD_W'(cfg.dir_setup_us);
      end
    end
  end

  // levels after the word
  always_comb begin
    res.step_pin       = phase_next == stp_pkg::PH_HIGH;
    res.dir_pin        = direction_next;
    res.position_steps = stp_pkg::VALUE_W'(position_next);
    res.busy_res       = phase_next != stp_pkg::PH_IDLE;
    res.status         = status;
  end

endmodule

// ===== hdl/stepper_step_dir_pulse_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_dir_pulse_generator_unit
// STEP/DIR pulse generator: relative, absolute and homing moves timed by ticks.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              handshake
//  req      in   req_type, step_value, period_us                     valid/ready
//  res      out  step_pin, dir_pin, position_steps, busy_res, status valid/ready
//  cfg      in   index, data                                          valid/ready
//
//  one word per cycle while the result is not stalled; a taken word passes the input
//  register, then the core update into the output register, before its result is valid
//  rst is synchronous: position zero, idle, registers at their defaults
//  a stalled result holds both stages; req.ready drops only when both are full
//  cfg.ready is always high
// ----------------------------------------------------------------------------
module stepper_step_dir_pulse_generator_unit #(
  parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  stp_req_if.sink          req,
  stp_res_if.source        res,
  stp_cfg_if.sink          cfg
);

  stp_pkg::cfg_t                       cfg_regs;
  logic                                s1_valid;
  logic [stp_pkg::REQ_W-1:0]           s1_req_type;
  logic signed [stp_pkg::VALUE_W-1:0]  s1_step_value;
  logic [stp_pkg::PERIOD_W-1:0]        s1_period_us;
  logic                                out_valid;
  stp_pkg::res_t                       out_word;
  stp_pkg::res_t                       core_res;
  logic                                out_free;
  logic                                fire;
  logic                                take;

  assign out_free  = ~out_valid | res.ready;
  assign fire      = s1_valid & out_free;
  assign req.ready = ~s1_valid | out_free;
  assign take      = req.valid & req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pulse_high_us     <= stp_pkg::PULSE_HIGH_RST;
      cfg_regs.dir_setup_us      <= stp_pkg::DIR_SETUP_RST;
      cfg_regs.home_travel_steps <= stp_pkg::HOME_TRAVEL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        stp_pkg::CFG_PULSE_HIGH:  cfg_regs.pulse_high_us <= cfg.data[stp_pkg::PULSE_W-1:0];
        stp_pkg::CFG_DIR_SETUP:   cfg_regs.dir_setup_us  <= cfg.data[stp_pkg::SETUP_W-1:0];
        stp_pkg::CFG_HOME_TRAVEL: cfg_regs.home_travel_steps <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_req_type   <= req.req_type;
      s1_step_value <= req.step_value;
      s1_period_us  <= req.period_us;
    end
    if (fire) begin
      out_word <= core_res;
    end
  end

  stp_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (s1_req_type),
    .step_value (s1_step_value),
    .period_us  (s1_period_us),
    .cfg        (cfg_regs),
    .res        (core_res)
  );

  assign res.valid          = out_valid;
  assign res.step_pin       = out_word.step_pin;
  assign res.dir_pin        = out_word.dir_pin;
  assign res.position_steps = out_word.position_steps;
  assign res.busy_res       = out_word.busy_res;
  assign res.status         = out_word.status;

endmodule
